// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/aspe_pkg.sv =====
// Package for the signal phase engine: types, codes, reset values and
// the green length and lane helper functions. No dependencies.
package aspe_pkg;

    localparam int LaneCount = 3;
    localparam int RotW      = 3;   // holds rotation index for up to 8 phases
    localparam int QDepth    = 2;   // front-to-back queue depth
    localparam int MsW       = 17;

    localparam logic [MsW-1:0] ElapsedMax = {MsW{1'b1}};

    // request codes on the input channel
    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_SET_AUTO = 2'd1;
    localparam logic [1:0] REQ_MANUAL   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_FIXED_GREEN = 3'd0;
    localparam logic [2:0] CFG_YELLOW      = 3'd1;
    localparam logic [2:0] CFG_ALL_RED     = 3'd2;
    localparam logic [2:0] CFG_MIN_GREEN   = 3'd3;
    localparam logic [2:0] CFG_MAX_GREEN   = 3'd4;
    localparam logic [2:0] CFG_STARTUP     = 3'd5;
    localparam logic [2:0] CFG_ADAPTIVE    = 3'd6;

    // register reset values
    localparam logic [16:0] RST_FIXED_GREEN = 17'd10000;
    localparam logic [14:0] RST_YELLOW      = 15'd3000;
    localparam logic [13:0] RST_ALL_RED     = 14'd2000;
    localparam logic [16:0] RST_MIN_GREEN   = 17'd10000;
    localparam logic [16:0] RST_MAX_GREEN   = 17'd60000;
    localparam logic [13:0] RST_STARTUP     = 14'd3000;
    localparam logic        RST_ADAPTIVE    = 1'b1;
    localparam logic [16:0] RST_CHOSEN      = 17'd10000;

    typedef enum logic [2:0] {
        PH_STARTUP  = 3'd0,
        PH_GREEN    = 3'd1,
        PH_YELLOW   = 3'd2,
        PH_CLEAR    = 3'd3,
        PH_MANUAL   = 3'd4,
        PH_FAILSAFE = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        LT_RED    = 2'd0,
        LT_YELLOW = 2'd1,
        LT_GREEN  = 2'd2
    } t_light;

    typedef enum logic [1:0] {
        RS_NONE     = 2'd0,
        RS_AUTO_ON  = 2'd1,
        RS_CONFLICT = 2'd2
    } t_reason;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_AUTO_ON,
        CMD_AUTO_OFF,
        CMD_MANUAL,
        CMD_NOP
    } t_cmd;

    typedef struct packed {
        logic [16:0] fixed_green;
        logic [14:0] yellow;
        logic [13:0] all_red;
        logic [16:0] min_green;
        logic [16:0] max_green;
        logic [13:0] startup;
        logic        adaptive;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        t_cmd                       cmd;
        logic [1:0]                 manual_lane;
        logic [LaneCount-1:0][16:0] cand;   // green length per lane
    } t_item;

    typedef struct packed {
        t_phase      phase;
        t_light      north;
        t_light      south;
        t_light      east;
        logic [1:0]  served;
        logic [16:0] green;
        logic        accepted;
        t_reason     reason;
    } t_result;

    function automatic logic [1:0] mod3(input logic [RotW-1:0] v);
        logic [1:0] r;
        unique case (v)
            3'd0, 3'd3, 3'd6: r = 2'd0;
            3'd1, 3'd4, 3'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] clamp_green(input logic [16:0] v,
                                                input logic [16:0] lo,
                                                input logic [16:0] hi);
        logic [16:0] r;
        priority if (v < lo) r = lo;
        else if (v > hi)     r = hi;
        else                 r = v;
        return r;
    endfunction

    function automatic logic [16:0] green_for(input t_cfg cfg,
                                              input logic [16:0] rec,
                                              input logic [1:0] lvl);
        logic [17:0] sum;
        logic [16:0] d;
        sum = {1'b0, cfg.min_green} + {1'b0, cfg.max_green};
        unique case (lvl)
            2'd2:    d = cfg.max_green;
            2'd1:    d = sum[17:1];
            default: d = cfg.min_green;   // level 0, and 3 read as 0
        endcase
        if (!cfg.adaptive)   d = cfg.fixed_green;
        else if (rec != '0)  d = rec;
        return clamp_green(d, cfg.min_green, cfg.max_green);
    endfunction

    // true when every approach other than lane shows red
    function automatic logic others_red(input t_light [LaneCount-1:0] asp,
                                        input logic [1:0] lane);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < LaneCount; k++) begin
            if (2'(k) != lane && asp[k] != LT_RED) ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

// ===== rtl/aspe_fifo.sv =====
// Small register queue between the front and back parts.
// Generic width and depth; no package dependency.
module aspe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_nonempty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wp, r_rp;
    logic [CntW-1:0]  r_cnt;
    logic             w_push, w_pop;

    assign o_full     = (r_cnt == CntFull);
    assign o_nonempty = (r_cnt != '0);
    assign o_data     = r_mem[r_rp];
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == PtrLast) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (r_rp == PtrLast) ? '0 : r_rp + 1'b1;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== rtl/aspe_front.sv =====
// Front part: decodes the request type and works out the clamped green
// length for each approach. Depends on aspe_pkg.
module aspe_front (
    input  aspe_pkg::t_cfg  i_cfg,
    input  logic [1:0]      i_req_type,
    input  logic            i_auto_value,
    input  logic [1:0]      i_manual_lane,
    input  logic [1:0]      i_north_level,
    input  logic [1:0]      i_south_level,
    input  logic [1:0]      i_east_level,
    input  logic [16:0]     i_north_rec_green_ms,
    input  logic [16:0]     i_south_rec_green_ms,
    input  logic [16:0]     i_east_rec_green_ms,
    output aspe_pkg::t_item o_item
);
    always_comb begin
        o_item.manual_lane = i_manual_lane;
        unique case (i_req_type)
            aspe_pkg::REQ_TICK:     o_item.cmd = aspe_pkg::CMD_TICK;
            aspe_pkg::REQ_SET_AUTO: o_item.cmd = i_auto_value ? aspe_pkg::CMD_AUTO_ON
                                                              : aspe_pkg::CMD_AUTO_OFF;
            aspe_pkg::REQ_MANUAL:   o_item.cmd = aspe_pkg::CMD_MANUAL;
            default:                o_item.cmd = aspe_pkg::CMD_NOP;
        endcase
        o_item.cand[0] = aspe_pkg::green_for(i_cfg, i_north_rec_green_ms, i_north_level);
        o_item.cand[1] = aspe_pkg::green_for(i_cfg, i_south_rec_green_ms, i_south_level);
        o_item.cand[2] = aspe_pkg::green_for(i_cfg, i_east_rec_green_ms, i_east_level);
    end

endmodule

// ===== rtl/aspe_back.sv =====
// Back part: phase sequencer, lane aspects, interval timer and the result
// register. Depends on aspe_pkg.
module aspe_back #(
    parameter int NUM_PHASES = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aspe_pkg::t_cfg    i_cfg,
    input  logic              i_q_valid,
    input  aspe_pkg::t_item   i_item,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output aspe_pkg::t_result o_result
);
    localparam logic [aspe_pkg::RotW-1:0] RotLast = aspe_pkg::RotW'(NUM_PHASES - 1);

    aspe_pkg::t_phase                            r_phase, n_phase;
    logic [aspe_pkg::RotW-1:0]                   r_rot, n_rot;
    logic [16:0]                                 r_elapsed, n_elapsed;
    logic [16:0]                                 r_green, n_green;
    aspe_pkg::t_light [aspe_pkg::LaneCount-1:0]  r_aspect, n_aspect;
    logic                                        r_auto, n_auto;
    logic                                        r_out_valid;
    aspe_pkg::t_result                           r_out, n_out;

    logic [16:0]               w_inc;
    logic [aspe_pkg::RotW-1:0] w_start_rot;
    logic [1:0]                w_start_lane;
    logic                      w_start_ok, w_man_ok;
    logic                      w_start, w_enter, w_all_red, w_to_yellow;

    assign o_pop       = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    assign w_inc = (r_elapsed == aspe_pkg::ElapsedMax) ? r_elapsed : r_elapsed + 17'd1;

    // a green start from clearance advances the rotation, all others restart at 0
    assign w_start_rot  = (i_item.cmd == aspe_pkg::CMD_TICK && r_phase == aspe_pkg::PH_CLEAR)
                          ? ((r_rot == RotLast) ? '0 : r_rot + 1'b1) : '0;
    assign w_start_lane = aspe_pkg::mod3(w_start_rot);
    assign w_start_ok   = aspe_pkg::others_red(r_aspect, w_start_lane);
    assign w_man_ok     = (i_item.manual_lane <= 2'd2)
                          && aspe_pkg::others_red(r_aspect, i_item.manual_lane);

    // next phase and sequencing events
    always_comb begin
        n_phase     = r_phase;
        n_rot       = r_rot;
        w_start     = 1'b0;
        w_enter     = 1'b0;
        w_all_red   = 1'b0;
        w_to_yellow = 1'b0;
        if (o_pop) begin
            unique case (i_item.cmd)
                aspe_pkg::CMD_TICK: begin
                    if (r_auto) begin
                        unique case (r_phase)
                            aspe_pkg::PH_STARTUP: begin
                                w_all_red = 1'b1;
                                if (w_inc >= {3'd0, i_cfg.startup}) w_start = 1'b1;
                            end
                            aspe_pkg::PH_GREEN: begin
                                if (w_inc >= r_green) begin
                                    w_to_yellow = 1'b1;
                                    w_enter     = 1'b1;
                                    n_phase     = aspe_pkg::PH_YELLOW;
                                end
                            end
                            aspe_pkg::PH_YELLOW: begin
                                if (w_inc >= {2'd0, i_cfg.yellow}) begin
                                    w_all_red = 1'b1;
                                    w_enter   = 1'b1;
                                    n_phase   = aspe_pkg::PH_CLEAR;
                                end
                            end
                            aspe_pkg::PH_CLEAR: begin
                                if (w_inc >= {3'd0, i_cfg.all_red}) w_start = 1'b1;
                            end
                            default: w_all_red = 1'b1;
                        endcase
                    end
                end
                aspe_pkg::CMD_AUTO_ON: w_start = 1'b1;
                aspe_pkg::CMD_AUTO_OFF: begin
                    w_all_red = 1'b1;
                    w_enter   = 1'b1;
                    n_phase   = aspe_pkg::PH_MANUAL;
                end
                aspe_pkg::CMD_MANUAL: begin
                    if (!r_auto && w_man_ok) begin
                        w_enter = 1'b1;
                        n_phase = aspe_pkg::PH_MANUAL;
                    end
                end
                default: ;
            endcase
        end
        if (w_start) begin
            n_rot   = w_start_rot;
            w_enter = 1'b1;
            n_phase = w_start_ok ? aspe_pkg::PH_GREEN : aspe_pkg::PH_FAILSAFE;
        end
    end

    // aspects, timer, green length and the result
    always_comb begin
        n_aspect  = r_aspect;
        n_elapsed = r_elapsed;
        n_green   = r_green;
        n_auto    = r_auto;
        n_out.accepted = 1'b0;
        n_out.reason   = aspe_pkg::RS_NONE;
        if (o_pop) begin
            unique case (i_item.cmd)
                aspe_pkg::CMD_TICK: begin
                    n_elapsed = w_inc;
                    if (w_to_yellow) n_aspect[aspe_pkg::mod3(r_rot)] = aspe_pkg::LT_YELLOW;
                end
                aspe_pkg::CMD_AUTO_ON: begin
                    n_auto         = 1'b1;
                    n_out.accepted = 1'b1;
                end
                aspe_pkg::CMD_AUTO_OFF: begin
                    n_auto         = 1'b0;
                    n_out.accepted = 1'b1;
                end
                aspe_pkg::CMD_MANUAL: begin
                    priority if (r_auto) begin
                        n_out.reason = aspe_pkg::RS_AUTO_ON;
                    end else if (w_man_ok) begin
                        n_aspect = {aspe_pkg::LaneCount{aspe_pkg::LT_RED}};
                        n_aspect[i_item.manual_lane] = aspe_pkg::LT_GREEN;
                        n_out.accepted = 1'b1;
                    end else begin
                        n_out.reason = aspe_pkg::RS_CONFLICT;
                    end
                end
                default: ;
            endcase
            if (w_all_red) n_aspect = {aspe_pkg::LaneCount{aspe_pkg::LT_RED}};
            if (w_start) begin
                n_green  = i_item.cand[w_start_lane];
                n_aspect = {aspe_pkg::LaneCount{aspe_pkg::LT_RED}};
                if (w_start_ok) n_aspect[w_start_lane] = aspe_pkg::LT_GREEN;
            end
            if (w_enter) n_elapsed = '0;
        end
        n_out.phase  = n_phase;
        n_out.north  = n_aspect[0];
        n_out.south  = n_aspect[1];
        n_out.east   = n_aspect[2];
        n_out.served = aspe_pkg::mod3(n_rot);
        n_out.green  = n_green;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= aspe_pkg::PH_STARTUP;
            r_rot       <= '0;
            r_elapsed   <= '0;
            r_green     <= aspe_pkg::RST_CHOSEN;
            r_aspect    <= {aspe_pkg::LaneCount{aspe_pkg::LT_RED}};
            r_auto      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_rot     <= n_rot;
            r_elapsed <= n_elapsed;
            r_green   <= n_green;
            r_aspect  <= n_aspect;
            r_auto    <= n_auto;
            if (o_pop)             r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_out <= n_out;
    end

endmodule

// ===== rtl/adaptive_signal_phase_engine_top.sv =====
// Channel     Direction  Handshake                  Payload
// input       in         i_in_valid / o_in_stall    request type, lane, levels, recs
// result      out        o_out_valid / i_out_stall  state, aspects, lane, green, status
// config      in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per clock sustained while the result side does not stall. A result becomes
// valid once its item has been registered in the front-to-back queue and the edge
// that pops it into the sequencer has loaded the result register. The sequencer
// state is registered and fed back into its own next-state logic.
// Reset is synchronous, active low; all but queue and result storage is restored.
// A stall on the result side fills the two-entry queue before o_in_stall rises.
// Top level of the signal phase engine: configuration registers, front,
// queue and back. Depends on aspe_pkg, aspe_front, aspe_fifo, aspe_back.
module adaptive_signal_phase_engine_top #(
    parameter int NUM_PHASES = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic        i_auto_value,
    input  logic [1:0]  i_manual_lane,
    input  logic [1:0]  i_north_level,
    input  logic [1:0]  i_south_level,
    input  logic [1:0]  i_east_level,
    input  logic [16:0] i_north_rec_green_ms,
    input  logic [16:0] i_south_rec_green_ms,
    input  logic [16:0] i_east_rec_green_ms,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_signal_state,
    output logic [1:0]  o_north_light,
    output logic [1:0]  o_south_light,
    output logic [1:0]  o_east_light,
    output logic [1:0]  o_served_lane,
    output logic [16:0] o_green_length_ms,
    output logic        o_accepted,
    output logic [1:0]  o_reject_reason,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    localparam int ItemW = $bits(aspe_pkg::t_item);

    aspe_pkg::t_cfg    r_cfg;
    aspe_pkg::t_item   w_front_item, w_q_item;
    aspe_pkg::t_result w_result;
    logic              w_q_full, w_q_nonempty, w_pop;
    logic [ItemW-1:0]  w_q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fixed_green <= aspe_pkg::RST_FIXED_GREEN;
            r_cfg.yellow      <= aspe_pkg::RST_YELLOW;
            r_cfg.all_red     <= aspe_pkg::RST_ALL_RED;
            r_cfg.min_green   <= aspe_pkg::RST_MIN_GREEN;
            r_cfg.max_green   <= aspe_pkg::RST_MAX_GREEN;
            r_cfg.startup     <= aspe_pkg::RST_STARTUP;
            r_cfg.adaptive    <= aspe_pkg::RST_ADAPTIVE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                aspe_pkg::CFG_FIXED_GREEN: r_cfg.fixed_green <= i_cfg_data;
                aspe_pkg::CFG_YELLOW:      r_cfg.yellow      <= i_cfg_data[14:0];
                aspe_pkg::CFG_ALL_RED:     r_cfg.all_red     <= i_cfg_data[13:0];
                aspe_pkg::CFG_MIN_GREEN:   r_cfg.min_green   <= i_cfg_data;
                aspe_pkg::CFG_MAX_GREEN:   r_cfg.max_green   <= i_cfg_data;
                aspe_pkg::CFG_STARTUP:     r_cfg.startup     <= i_cfg_data[13:0];
                aspe_pkg::CFG_ADAPTIVE:    r_cfg.adaptive    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    aspe_front u_front (
        .i_cfg                (r_cfg),
        .i_req_type           (i_req_type),
        .i_auto_value         (i_auto_value),
        .i_manual_lane        (i_manual_lane),
        .i_north_level        (i_north_level),
        .i_south_level        (i_south_level),
        .i_east_level         (i_east_level),
        .i_north_rec_green_ms (i_north_rec_green_ms),
        .i_south_rec_green_ms (i_south_rec_green_ms),
        .i_east_rec_green_ms  (i_east_rec_green_ms),
        .o_item               (w_front_item)
    );

    assign o_in_stall = w_q_full;

    aspe_fifo #(
        .WIDTH (ItemW),
        .DEPTH (aspe_pkg::QDepth)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_in_valid),
        .i_data     (w_front_item),
        .o_full     (w_q_full),
        .i_pop      (w_pop),
        .o_nonempty (w_q_nonempty),
        .o_data     (w_q_data)
    );

    assign w_q_item = aspe_pkg::t_item'(w_q_data);

    aspe_back #(
        .NUM_PHASES (NUM_PHASES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_nonempty),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (w_result)
    );

    assign o_signal_state    = w_result.phase;
    assign o_north_light     = w_result.north;
    assign o_south_light     = w_result.south;
    assign o_east_light      = w_result.east;
    assign o_served_lane     = w_result.served;
    assign o_green_length_ms = w_result.green;
    assign o_accepted        = w_result.accepted;
    assign o_reject_reason   = w_result.reason;

endmodule

// ===== rtl/aspe_checker.sv =====
// Port-level checker for the signal phase engine, bound to the top level.
// Depends on aspe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module aspe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_signal_state,
    input logic [1:0]  o_north_light,
    input logic [1:0]  o_south_light,
    input logic [1:0]  o_east_light,
    input logic [16:0] o_green_length_ms,
    input logic        o_accepted,
    input logic [1:0]  o_reject_reason
);
    logic w_all_red, w_one_green, w_red_state, w_green_state;

    assign w_all_red = (o_north_light == aspe_pkg::LT_RED)
                    && (o_south_light == aspe_pkg::LT_RED)
                    && (o_east_light == aspe_pkg::LT_RED);
    assign w_one_green = $onehot({o_north_light == aspe_pkg::LT_GREEN,
                                  o_south_light == aspe_pkg::LT_GREEN,
                                  o_east_light == aspe_pkg::LT_GREEN})
                      && ((o_north_light == aspe_pkg::LT_RED)
                          + (o_south_light == aspe_pkg::LT_RED)
                          + (o_east_light == aspe_pkg::LT_RED)) == 2;
    assign w_red_state = (o_signal_state == aspe_pkg::PH_STARTUP)
                      || (o_signal_state == aspe_pkg::PH_CLEAR)
                      || (o_signal_state == aspe_pkg::PH_FAILSAFE);
    assign w_green_state = (o_signal_state == aspe_pkg::PH_GREEN);

    // a stalled result stays put
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_signal_state) && $stable(o_green_length_ms),
        "result changed under stall")

    `ASSERT_IMPLY(a_green_one_lane, i_clk, i_rst_n,
        o_out_valid && w_green_state, w_one_green, "green phase not exclusive")

    `ASSERT_IMPLY(a_red_states, i_clk, i_rst_n,
        o_out_valid && w_red_state, w_all_red, "light shown in all-red state")

    `ASSERT_IMPLY(a_status_excl, i_clk, i_rst_n,
        o_out_valid && o_accepted, o_reject_reason == aspe_pkg::RS_NONE,
        "accepted with reject reason")

    `ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_out_valid && !o_in_stall, "outputs busy after reset")

endmodule

bind adaptive_signal_phase_engine_top aspe_checker u_aspe_checker (.*);
